// ===== sv/ihex_pkg.sv =====
package ihex_pkg;

   localparam int RECORD_BYTES = 16;
   localparam int BUF_DEPTH    = 16;
   localparam int IDX_W        = $clog2(BUF_DEPTH);
   localparam int FILL_W       = $clog2(BUF_DEPTH + 1);
   localparam int ADDR_W       = 16;
   localparam int PC_W         = 5;

   localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(RECORD_BYTES);

   // entry points of the microprogram
   localparam logic [PC_W-1:0] PC_RECORD = 5'd0;
   localparam logic [PC_W-1:0] PC_DATA   = 5'd9;
   localparam logic [PC_W-1:0] PC_EOF    = 5'd14;

   typedef enum logic [1:0] {
      CS_CONST,
      CS_HEX_HI,
      CS_HEX_LO
   } char_src_type;

   typedef enum logic [2:0] {
      BS_COUNT,
      BS_ADDR_HI,
      BS_ADDR_LO,
      BS_ZERO,
      BS_DATA,
      BS_CSUM
   } byte_sel_type;

   typedef struct packed {
      char_src_type src;
      byte_sel_type sel;
      logic [7:0]   ch;
      logic         acc;      // add selected byte into checksum
      logic         loop;     // next data byte, branch back while bytes remain
      logic         rec_end;  // advance address; branch to end record on finish
      logic         img_end;  // clear image state, stop
   } uop_type;

   function automatic uop_type ucode(input logic [PC_W-1:0] pc);
      uop_type u;
      u.src     = CS_CONST;
      u.sel     = BS_ZERO;
      u.ch      = 8'h00;
      u.acc     = 1'b0;
      u.loop    = 1'b0;
      u.rec_end = 1'b0;
      u.img_end = 1'b0;
      case (pc)
         5'd0: begin
            u.ch = ":";
         end
         5'd1: begin
            u.src = CS_HEX_HI; u.sel = BS_COUNT; u.acc = 1'b1;
         end
         5'd2: begin
            u.src = CS_HEX_LO; u.sel = BS_COUNT;
         end
         5'd3: begin
            u.src = CS_HEX_HI; u.sel = BS_ADDR_HI; u.acc = 1'b1;
         end
         5'd4: begin
            u.src = CS_HEX_LO; u.sel = BS_ADDR_HI;
         end
         5'd5: begin
            u.src = CS_HEX_HI; u.sel = BS_ADDR_LO; u.acc = 1'b1;
         end
         5'd6: begin
            u.src = CS_HEX_LO; u.sel = BS_ADDR_LO;
         end
         5'd7: begin
            u.src = CS_HEX_HI; u.sel = BS_ZERO;
         end
         5'd8: begin
            u.src = CS_HEX_LO; u.sel = BS_ZERO;
         end
         5'd9: begin
            u.src = CS_HEX_HI; u.sel = BS_DATA; u.acc = 1'b1;
         end
         5'd10: begin
            u.src = CS_HEX_LO; u.sel = BS_DATA; u.loop = 1'b1;
         end
         5'd11: begin
            u.src = CS_HEX_HI; u.sel = BS_CSUM;
         end
         5'd12: begin
            u.src = CS_HEX_LO; u.sel = BS_CSUM;
         end
         5'd13: begin
            u.ch = 8'h0a; u.rec_end = 1'b1;
         end
         // end-of-file record, upper case checksum as in the file format
         5'd14: u.ch = ":";
         5'd15: u.ch = "0";
         5'd16: u.ch = "0";
         5'd17: u.ch = "0";
         5'd18: u.ch = "0";
         5'd19: u.ch = "0";
         5'd20: u.ch = "0";
         5'd21: u.ch = "0";
         5'd22: u.ch = "1";
         5'd23: u.ch = "F";
         5'd24: u.ch = "F";
         5'd25: begin
            u.ch = 8'h0a; u.img_end = 1'b1;
         end
         default: u.ch = 8'h00;
      endcase
      return u;
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] n);
      logic [7:0] c;
      if (n < 4'd10) begin
         c = 8'h30 + {4'h0, n};
      end else begin
         c = 8'h57 + {4'h0, n};
      end
      return c;
   endfunction

endpackage

// ===== sv/intel_hex_record_encoder.sv =====
// Output: the word that completes a record sets the busy flag; the sequencer
//   then registers the first character into the output register, and then
//   one character per cycle while rsp_ready stays high.
// Input: data bytes are refused while a record's text is emitted; a finish
//   holds the input until any partial record and the end record are out.
// Reset: synchronous; clears fill count, address, wrap flag and sequencer.
module intel_hex_record_encoder
   import ihex_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_command,
   input  logic [7:0] req_data_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_text_char,
   output logic       rsp_run_end,
   output logic       rsp_address_wrapped
);

   logic [7:0]        buf_mem [BUF_DEPTH];
   logic [7:0]        rd_byte_ff;

   logic              busy_ff,   busy_in;
   logic              finish_ff, finish_in;
   logic [PC_W-1:0]   pc_ff,     pc_in;
   logic [IDX_W-1:0]  idx_ff,    idx_in;
   logic [FILL_W-1:0] fill_ff,   fill_in;
   logic [ADDR_W-1:0] addr_ff,   addr_in;
   logic              wrap_ff,   wrap_in;
   logic [7:0]        sum_ff,    sum_in;

   logic              rsp_valid_ff,   rsp_valid_in;
   logic [7:0]        rsp_char_ff,    rsp_char_in;
   logic              rsp_end_ff,     rsp_end_in;
   logic              rsp_wrap_ff,    rsp_wrap_in;

   uop_type           uop;
   logic              in_accept;
   logic              step;
   logic [7:0]        sel_byte;
   logic [7:0]        out_char;
   logic [ADDR_W:0]   addr_sum;
   logic [FILL_W-1:0] fill_inc;

   assign req_ready = !busy_ff;
   assign in_accept = req_valid && req_ready;
   assign step      = busy_ff && (!rsp_valid_ff || rsp_ready);
   assign uop       = ucode(pc_ff);
   assign addr_sum  = {1'b0, addr_ff} + (ADDR_W + 1)'(fill_ff);
   assign fill_inc  = fill_ff + FILL_W'(1);

   always_comb begin
      case (uop.sel)
         BS_COUNT:   sel_byte = 8'(fill_ff);
         BS_ADDR_HI: sel_byte = addr_ff[15:8];
         BS_ADDR_LO: sel_byte = addr_ff[7:0];
         BS_DATA:    sel_byte = rd_byte_ff;
         BS_CSUM:    sel_byte = ~sum_ff + 8'd1;
         default:    sel_byte = 8'h00;
      endcase
      case (uop.src)
         CS_HEX_HI: out_char = hex_char(sel_byte[7:4]);
         CS_HEX_LO: out_char = hex_char(sel_byte[3:0]);
         default:   out_char = uop.ch;
      endcase
   end

   always_comb begin
      busy_in      = busy_ff;
      finish_in    = finish_ff;
      pc_in        = pc_ff;
      idx_in       = idx_ff;
      fill_in      = fill_ff;
      addr_in      = addr_ff;
      wrap_in      = wrap_ff;
      sum_in       = sum_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_char_in  = rsp_char_ff;
      rsp_end_in   = rsp_end_ff;
      rsp_wrap_in  = rsp_wrap_ff;

      if (step) begin
         rsp_valid_in = 1'b1;
         rsp_char_in  = out_char;
         rsp_end_in   = 1'b0;
         rsp_wrap_in  = wrap_ff;
         pc_in        = pc_ff + PC_W'(1);
         if (uop.acc) begin
            sum_in = sum_ff + sel_byte;
         end
         if (uop.loop) begin
            if (FILL_W'(idx_ff) + FILL_W'(1) < fill_ff) begin
               pc_in  = PC_DATA;
               idx_in = idx_ff + IDX_W'(1);
            end else begin
               idx_in = '0;
            end
         end
         if (uop.rec_end) begin
            addr_in = addr_sum[ADDR_W-1:0];
            if (addr_sum[ADDR_W]) begin
               wrap_in = 1'b1;
            end
            fill_in = '0;
            if (finish_ff) begin
               pc_in = PC_EOF;
            end else begin
               busy_in    = 1'b0;
               rsp_end_in = 1'b1;
            end
         end
         if (uop.img_end) begin
            addr_in    = '0;
            wrap_in    = 1'b0;
            fill_in    = '0;
            busy_in    = 1'b0;
            rsp_end_in = 1'b1;
         end
      end

      if (in_accept) begin
         sum_in = 8'h00;
         idx_in = '0;
         if (!req_command) begin
            fill_in = fill_inc;
            if (fill_inc == FILL_FULL) begin
               busy_in   = 1'b1;
               finish_in = 1'b0;
               pc_in     = PC_RECORD;
            end
         end else begin
            busy_in   = 1'b1;
            finish_in = 1'b1;
            // empty buffer: straight to the end record
            pc_in     = (fill_ff != '0) ? PC_RECORD : PC_EOF;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         finish_ff    <= 1'b0;
         pc_ff        <= '0;
         idx_ff       <= '0;
         fill_ff      <= '0;
         addr_ff      <= '0;
         wrap_ff      <= 1'b0;
         sum_ff       <= 8'h00;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         finish_ff    <= finish_in;
         pc_ff        <= pc_in;
         idx_ff       <= idx_in;
         fill_ff      <= fill_in;
         addr_ff      <= addr_in;
         wrap_ff      <= wrap_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_char_ff <= rsp_char_in;
      rsp_end_ff  <= rsp_end_in;
      rsp_wrap_ff <= rsp_wrap_in;
   end

   // read ahead at the next index; data steps come well after the last write
   always_ff @(posedge clock) begin
      if (in_accept && !req_command) begin
         buf_mem[fill_ff[IDX_W-1:0]] <= req_data_byte;
      end
      rd_byte_ff <= buf_mem[idx_in];
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_text_char       = rsp_char_ff;
   assign rsp_run_end         = rsp_end_ff;
   assign rsp_address_wrapped = rsp_wrap_ff;

endmodule

// ===== sv/ihex_checker.sv =====
module ihex_checker
   import ihex_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       req_command,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_text_char,
   input logic       rsp_run_end
);

   // a stalled word holds its character
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_text_char))
      else $error("rsp word changed while stalled");

   // a finish always produces output, so the input side must close
   a_finish_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_command |=> !req_ready)
      else $error("finish accepted without going busy");

   // every run ends on a newline
   a_run_end_nl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_run_end |-> rsp_text_char == 8'h0a)
      else $error("run end not on newline");

   // a word after a run end starts a new record
   a_new_record: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_run_end ##1 rsp_valid
      |-> rsp_text_char == 8'h3a)
      else $error("record does not open with colon");

endmodule

bind intel_hex_record_encoder ihex_checker u_ihex_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_ready     (req_ready),
   .req_command   (req_command),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_text_char (rsp_text_char),
   .rsp_run_end   (rsp_run_end)
);
